### rtl/joint_setpoint_trajectory_smoother_top_defines.svh
// assertion macros for the trajectory smoother top level
// expects signals named clk and rst in the including module
`ifndef JOINT_SETPOINT_TRAJECTORY_SMOOTHER_TOP_DEFINES_SVH
`define JOINT_SETPOINT_TRAJECTORY_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define JSTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsts check failed");

// next-cycle implication, disabled during reset
`define JSTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsts check failed");

`endif

### rtl/jsts_pkg.sv
`timescale 1ns / 1ps
// jsts_pkg: widths, register codes, joint limits and the easing table
// no dependencies; used by jsts_div and the top level
package jsts_pkg;

  localparam int EASE_TABLE_DEPTH = 256;
  localparam int ANGLE_FRAC_BITS  = 10;

  localparam int ANGLE_W  = 16;
  localparam int Q16_BITS = 16;
  localparam int EASE_W   = Q16_BITS + 1;
  localparam int TAB_AW   = $clog2(EASE_TABLE_DEPTH + 1);
  localparam int MUL_W    = 17;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int TICK_W   = 32;
  localparam int THRESH_W = 10;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 16;
  localparam int JOINTS   = 3;

  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam longint unsigned EASE_U_DEN = 2 * EASE_TABLE_DEPTH;

  localparam logic [EASE_W-1:0] Q16_ONE = EASE_W'(1) << Q16_BITS;

  localparam logic [Q16_BITS-1:0] GAIN_RESET     = 16'd19661;
  localparam logic [Q16_BITS-1:0] DURATION_RESET = 16'd1500;
  localparam logic [THRESH_W-1:0] THRESH_RESET   = 10'd1;

  typedef enum logic [CFG_AW-1:0] {
    REG_SMOOTHING_GAIN   = 4'd0,
    REG_MAIN_DURATION    = 4'd1,
    REG_OTHER_DURATION   = 4'd2,
    REG_CHANGE_THRESHOLD = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                start;
    logic [Q16_BITS-1:0] num;
    logic [Q16_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [Q16_BITS-1:0] quot;
  } div_rsp_t;

  // hundredths of a radian to angle lsbs, rounded
  function automatic longint ang_hund(input longint h);
    return (h * (longint'(1) <<< ANGLE_FRAC_BITS) + 50) / 100;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (ANGLE_W - 1)) - 1;
    lo_lim = -(longint'(1) <<< (ANGLE_W - 1));
    if (v > hi_lim) return ANGLE_W'(hi_lim);
    if (v < lo_lim) return ANGLE_W'(lo_lim);
    return ANGLE_W'(v);
  endfunction

  localparam int JOINT_LO [JOINTS] = '{
    -int'(ang_hund(1300)), -int'(ang_hund(129)), -int'(ang_hund(1900))
  };
  localparam int JOINT_HI [JOINTS] = '{
    int'(ang_hund(122)), int'(ang_hund(1200)), int'(ang_hund(380))
  };
  localparam logic signed [ANGLE_W-1:0] HOME_POSE [JOINTS] = '{
    sat_angle(ang_hund(123)), sat_angle(ang_hund(136)), sat_angle(-ang_hund(370))
  };

  // sin^2 by a fixed-point taylor series, first half of the table
  function automatic logic [EASE_W-1:0] ease_first_half(input int unsigned k);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned mag;
    longint unsigned s;
    longint unsigned sq;
    u   = (PI_Q30 * longint'(k)) / EASE_U_DEN;
    u2  = (u * u) >> 30;
    mag = u;
    s   = u;
    mag = ((mag * u2) >> 30) / 64'd6;
    s   = s - mag;
    mag = ((mag * u2) >> 30) / 64'd20;
    s   = s + mag;
    mag = ((mag * u2) >> 30) / 64'd42;
    s   = s - mag;
    mag = ((mag * u2) >> 30) / 64'd72;
    s   = s + mag;
    mag = ((mag * u2) >> 30) / 64'd110;
    s   = s - mag;
    sq = (s * s + (64'd1 << 43)) >> 44;
    return EASE_W'(sq);
  endfunction

  typedef logic [EASE_W-1:0] ease_tab_t [EASE_TABLE_DEPTH + 1];

  function automatic ease_tab_t build_ease_tab();
    ease_tab_t tab;
    int k;
    for (k = 0; k <= EASE_TABLE_DEPTH; k++) begin
      if (2 * k <= EASE_TABLE_DEPTH) begin
        tab[k] = ease_first_half(k);
      end else begin
        tab[k] = Q16_ONE - ease_first_half(EASE_TABLE_DEPTH - k);
      end
    end
    return tab;
  endfunction

  localparam ease_tab_t EASE_TAB = build_ease_tab();

endpackage

### rtl/jsts_div.sv
`timescale 1ns / 1ps
// jsts_div: radix-2 restoring divider, one quotient bit per cycle
// computes (num << 16) / den for num < den; depends on jsts_pkg
module jsts_div
  import jsts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(Q16_BITS + 1);

  logic [Q16_BITS-1:0] rem;
  logic [Q16_BITS-1:0] den;
  logic [Q16_BITS-1:0] quot;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [Q16_BITS:0]   trial;
  logic                fits;

  always_comb begin
    trial = {rem, 1'b0};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.num;
        den  <= req.den;
        quot <= '0;
        cnt  <= CNT_W'(Q16_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? Q16_BITS'(trial - {1'b0, den}) : trial[Q16_BITS-1:0];
        quot <= {quot[Q16_BITS-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

### rtl/joint_setpoint_trajectory_smoother_top.sv
`timescale 1ns / 1ps
// joint_setpoint_trajectory_smoother_top: raised-cosine move and idle follow for three joints
// depends on jsts_pkg, jsts_div and the assertion macro header
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid/in_ready, goal_*, now_tick             | sink
//   out     | out_valid/out_ready, setpoint_*, moving         | source
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | sink
//
// idle step: threshold check, three multiply/round passes, output load
// move step: dominated by two runs of the shared divider
//   for the two progress values, then two table interpolations on the shared multiplier
// in_ready is high only in the idle state; a finished transaction waits in the output register
// while the next input transaction is taken; cfg writes are always accepted
// synchronous active-high reset restores the home pose and register defaults
`include "joint_setpoint_trajectory_smoother_top_defines.svh"

module joint_setpoint_trajectory_smoother_top
  import jsts_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] goal_first,
  input  logic signed [ANGLE_W-1:0] goal_second,
  input  logic signed [ANGLE_W-1:0] goal_third,
  input  logic [TICK_W-1:0]         now_tick,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ANGLE_W-1:0] setpoint_first,
  output logic signed [ANGLE_W-1:0] setpoint_second,
  output logic signed [ANGLE_W-1:0] setpoint_third,
  output logic                      moving,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_AW-1:0]         cfg_index,
  input  logic [CFG_DW-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ELAPSED,
    S_PROG_MAIN,
    S_WAIT_MAIN,
    S_PROG_REST,
    S_WAIT_REST,
    S_E_IDX,
    S_E_RDA,
    S_E_RDB,
    S_E_MUL,
    S_E_ADD,
    S_B_MUL,
    S_B_ADD,
    S_DONE
  } state_t;

  localparam int BV_W = ANGLE_W + 3;
  localparam int JI_W = $clog2(JOINTS);

  state_t state;

  logic [Q16_BITS-1:0] gain;
  logic [Q16_BITS-1:0] dur_main;
  logic [Q16_BITS-1:0] dur_rest;
  logic [THRESH_W-1:0] thresh;

  logic signed [ANGLE_W-1:0] goal_q   [JOINTS];
  logic signed [ANGLE_W-1:0] latched  [JOINTS];
  logic signed [ANGLE_W-1:0] origin   [JOINTS];
  logic signed [ANGLE_W-1:0] cur      [JOINTS];
  logic [TICK_W-1:0]         now_q;
  logic [TICK_W-1:0]         start_tick;
  logic [TICK_W-1:0]         elapsed;
  logic                      active;
  logic                      use_move;
  logic [EASE_W-1:0]         t_main;
  logic [EASE_W-1:0]         t_rest;
  logic [EASE_W-1:0]         e_main;
  logic [EASE_W-1:0]         e_rest;
  logic                      ease_sel;
  logic [EASE_W-1:0]         tab_q;
  logic [EASE_W-1:0]         ease_a;
  logic [PROD_W-1:0]         prod;
  logic [JI_W-1:0]           jidx;
  logic                      dneg;

  logic                      changed;
  logic [ANGLE_W:0]          diff;
  logic [ANGLE_W:0]          absd;
  logic                      main_full;
  logic                      rest_full;
  logic [EASE_W-1:0]         t_cur;
  logic [TAB_AW-1:0]         ease_idx;
  logic [TAB_AW-1:0]         tab_addr;
  logic [EASE_W-1:0]         ease_d;
  logic signed [ANGLE_W-1:0] b_a;
  logic signed [ANGLE_W-1:0] b_b;
  logic [EASE_W-1:0]         b_f;
  logic [ANGLE_W:0]          blend_d;
  logic [ANGLE_W:0]          blend_mag;
  logic [MUL_W-1:0]          mul_a;
  logic [MUL_W-1:0]          mul_b;
  logic [PROD_W-1:0]         mul_res;
  logic [EASE_W-1:0]         rnd;
  logic signed [BV_W-1:0]    blend_v;
  int                        blend_i;
  logic signed [ANGLE_W-1:0] clamped;
  state_t                    ease_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  jsts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // change detection against the latched goals
  always_comb begin
    changed = 1'b0;
    diff    = '0;
    absd    = '0;
    for (int j = 0; j < JOINTS; j++) begin
      diff = {goal_q[j][ANGLE_W-1], goal_q[j]} - {latched[j][ANGLE_W-1], latched[j]};
      absd = diff[ANGLE_W] ? -diff : diff;
      if (absd > (ANGLE_W + 1)'(thresh)) changed = 1'b1;
    end
  end

  always_comb begin
    main_full = elapsed >= TICK_W'(dur_main);
    rest_full = elapsed >= TICK_W'(dur_rest);

    div_req.start = (state == S_PROG_MAIN && !main_full) ||
                    (state == S_PROG_REST && !rest_full);
    div_req.num   = elapsed[Q16_BITS-1:0];
    div_req.den   = (state == S_PROG_REST) ? dur_rest : dur_main;

    t_cur     = ease_sel ? t_rest : t_main;
    ease_idx  = prod[Q16_BITS +: TAB_AW];
    tab_addr  = (state == S_E_RDB) ? ease_idx + TAB_AW'(1) : ease_idx;
    ease_d    = (tab_q > ease_a) ? tab_q - ease_a : '0;
    ease_next = ease_sel ? S_B_MUL : S_E_IDX;

    b_a = use_move ? origin[jidx] : cur[jidx];
    b_b = latched[jidx];
    if (!use_move) b_f = EASE_W'(gain);
    else if (jidx == '0) b_f = e_main;
    else b_f = e_rest;
    blend_d   = {b_b[ANGLE_W-1], b_b} - {b_a[ANGLE_W-1], b_a};
    blend_mag = blend_d[ANGLE_W] ? -blend_d : blend_d;

    case (state)
      S_E_IDX: begin
        mul_a = MUL_W'(t_cur);
        mul_b = MUL_W'(EASE_TABLE_DEPTH);
      end
      S_E_MUL: begin
        mul_a = MUL_W'(ease_d);
        mul_b = MUL_W'(prod[Q16_BITS-1:0]);
      end
      S_B_MUL: begin
        mul_a = MUL_W'(blend_mag);
        mul_b = MUL_W'(b_f);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

    // round half up, drop the q16 fraction
    rnd = EASE_W'((prod + (PROD_W'(1) << (Q16_BITS - 1))) >> Q16_BITS);

    blend_v = dneg ? BV_W'(b_a) - BV_W'(rnd) : BV_W'(b_a) + BV_W'(rnd);
    blend_i = int'(blend_v);
    if (blend_i > JOINT_HI[jidx]) blend_i = JOINT_HI[jidx];
    if (blend_i < JOINT_LO[jidx]) blend_i = JOINT_LO[jidx];
    clamped = sat_angle(longint'(blend_i));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gain       <= GAIN_RESET;
      dur_main   <= DURATION_RESET;
      dur_rest   <= DURATION_RESET;
      thresh     <= THRESH_RESET;
      latched    <= HOME_POSE;
      origin     <= HOME_POSE;
      cur        <= HOME_POSE;
      start_tick <= '0;
      active     <= 1'b0;
      use_move   <= 1'b0;
      ease_sel   <= 1'b0;
      jidx       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SMOOTHING_GAIN:   gain     <= cfg_data;
          REG_MAIN_DURATION:    dur_main <= cfg_data;
          REG_OTHER_DURATION:   dur_rest <= cfg_data;
          REG_CHANGE_THRESHOLD: thresh   <= cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            goal_q[0] <= goal_first;
            goal_q[1] <= goal_second;
            goal_q[2] <= goal_third;
            now_q     <= now_tick;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (changed) begin
            latched    <= goal_q;
            origin     <= cur;
            start_tick <= now_q;
            active     <= 1'b1;
          end
          use_move <= changed || active;
          jidx     <= '0;
          ease_sel <= 1'b0;
          state    <= (changed || active) ? S_ELAPSED : S_B_MUL;
        end
        S_ELAPSED: begin
          elapsed <= now_q - start_tick;
          state   <= S_PROG_MAIN;
        end
        S_PROG_MAIN: begin
          if (main_full) begin
            t_main <= Q16_ONE;
            state  <= S_PROG_REST;
          end else begin
            state <= S_WAIT_MAIN;
          end
        end
        S_WAIT_MAIN: begin
          if (div_rsp.done) begin
            t_main <= EASE_W'(div_rsp.quot);
            state  <= S_PROG_REST;
          end
        end
        S_PROG_REST: begin
          if (rest_full) begin
            t_rest <= Q16_ONE;
            active <= 1'b0;
            state  <= S_E_IDX;
          end else begin
            state <= S_WAIT_REST;
          end
        end
        S_WAIT_REST: begin
          if (div_rsp.done) begin
            t_rest <= EASE_W'(div_rsp.quot);
            state  <= S_E_IDX;
          end
        end
        S_E_IDX: begin
          if (t_cur[Q16_BITS]) begin
            if (ease_sel) e_rest <= Q16_ONE;
            else e_main <= Q16_ONE;
            ease_sel <= 1'b1;
            state    <= ease_next;
          end else begin
            prod  <= mul_res;
            state <= S_E_RDA;
          end
        end
        S_E_RDA: begin
          tab_q <= EASE_TAB[tab_addr];
          state <= S_E_RDB;
        end
        S_E_RDB: begin
          ease_a <= tab_q;
          tab_q  <= EASE_TAB[tab_addr];
          state  <= S_E_MUL;
        end
        S_E_MUL: begin
          prod  <= mul_res;
          state <= S_E_ADD;
        end
        S_E_ADD: begin
          if (ease_sel) e_rest <= ease_a + rnd;
          else e_main <= ease_a + rnd;
          ease_sel <= 1'b1;
          state    <= ease_next;
        end
        S_B_MUL: begin
          prod  <= mul_res;
          dneg  <= blend_d[ANGLE_W];
          state <= S_B_ADD;
        end
        S_B_ADD: begin
          cur[jidx] <= clamped;
          if (jidx == JI_W'(JOINTS - 1)) begin
            state <= S_DONE;
          end else begin
            jidx  <= jidx + JI_W'(1);
            state <= S_B_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            setpoint_first  <= cur[0];
            setpoint_second <= cur[1];
            setpoint_third  <= cur[2];
            moving          <= active;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  `JSTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `JSTS_ASSERT_IMPL(a_div_done_in_wait, div_rsp.done, state == S_WAIT_MAIN || state == S_WAIT_REST)
  `JSTS_ASSERT_IMPL(a_first_in_limits, out_valid, int'(setpoint_first) >= JOINT_LO[0] && int'(setpoint_first) <= JOINT_HI[0])

endmodule
